### rtl/apdu_fr_pkg.sv
package apdu_fr_pkg;

  localparam int MAX_BEATS  = 7;
  localparam int LEN_W      = 17;
  localparam int BEAT_CNT_W = 3;

  // Register indexes of the configuration port
  localparam logic CFG_PROTOCOL_T1     = 1'b0;
  localparam logic CFG_BUFFER_CAPACITY = 1'b1;

  localparam logic [LEN_W-1:0] CAPACITY_RESET = 17'd65544;

  // Case type codes
  localparam logic [2:0] CASE1    = 3'd0;
  localparam logic [2:0] CASE2S   = 3'd1;
  localparam logic [2:0] CASE2E   = 3'd2;
  localparam logic [2:0] CASE3S   = 3'd3;
  localparam logic [2:0] CASE3E   = 3'd4;
  localparam logic [2:0] CASE4S   = 3'd5;
  localparam logic [2:0] CASE4E   = 3'd6;
  localparam logic [2:0] CASE_BAD = 3'd7;

  // Item kind carried on the input tuser
  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_DATA   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CASE = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_T0_LC    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DATA   = 2'd1,
    PH_SUFFIX = 2'd2
  } phase_t;

  typedef struct packed {
    logic        mode;
    logic [2:0]  case_type;
    logic [7:0]  class_byte;
    logic [7:0]  instruction_byte;
    logic [7:0]  param_one;
    logic [7:0]  param_two;
    logic [15:0] command_length;
    logic [15:0] expected_length;
    logic [7:0]  data_byte;
  } item_t;

  // One burst of result beats produced by one input item
  typedef struct packed {
    logic [MAX_BEATS-1:0][7:0] bytes;
    logic [BEAT_CNT_W-1:0]     count;
    logic                      last;
    status_t                   status;
    logic [LEN_W-1:0]          length;
  } burst_t;

endpackage

### rtl/apdu_fr_core.sv
module apdu_fr_core
  import apdu_fr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  item_t            item,
  input  logic             protocol_t1,
  input  logic [LEN_W-1:0] buffer_capacity,
  output burst_t           burst
);

  phase_t           phase, phase_next;
  logic [15:0]      data_remaining, data_remaining_next;
  logic [2:0]       held_case;
  logic [15:0]      held_expected;
  logic [LEN_W-1:0] held_length;
  logic             held_t1;
  logic             latch_header;

  logic [LEN_W-1:0] hdr_len;
  status_t          hdr_status;
  logic [16:0]      lc_ext;
  logic             hdr_suffix;
  logic             held_suffix;
  logic [15:0]      rem_dec;

  assign lc_ext      = {1'b0, item.command_length};
  assign held_suffix = held_t1 && (held_case == CASE4S || held_case == CASE4E);
  assign rem_dec     = data_remaining - 16'd1;

  // Frame length and header checks
  always_comb begin
    case (item.case_type)
      CASE1:   hdr_len = protocol_t1 ? 17'd4 : 17'd5;
      CASE2S:  hdr_len = 17'd5;
      CASE2E:  hdr_len = protocol_t1 ? 17'd7 : 17'd5;
      CASE3S:  hdr_len = lc_ext + 17'd5;
      CASE3E:  hdr_len = lc_ext + (protocol_t1 ? 17'd7 : 17'd5);
      CASE4S:  hdr_len = lc_ext + (protocol_t1 ? 17'd6 : 17'd5);
      CASE4E:  hdr_len = lc_ext + (protocol_t1 ? 17'd9 : 17'd5);
      default: hdr_len = '0;
    endcase
    hdr_suffix = protocol_t1 && (item.case_type == CASE4S || item.case_type == CASE4E);
    if (item.case_type == CASE_BAD) begin
      hdr_status = ST_BAD_CASE;
    end else if (hdr_len > buffer_capacity) begin
      hdr_status = ST_OVERFLOW;
    end else if (!protocol_t1 && (item.case_type == CASE3E || item.case_type == CASE4E)
                 && item.command_length[15:8] != 8'd0) begin
      hdr_status = ST_T0_LC;
    end else begin
      hdr_status = ST_OK;
    end
  end

  // Burst build and next state
  always_comb begin
    burst               = '0;
    phase_next          = phase;
    data_remaining_next = data_remaining;
    latch_header        = 1'b0;
    burst.length        = held_length;
    burst.status        = ST_OK;
    if (item.mode == MODE_HEADER) begin
      phase_next   = PH_IDLE;
      burst.length = hdr_len;
      burst.status = hdr_status;
      if (hdr_status != ST_OK) begin
        burst.count = 3'd1;
        burst.last  = 1'b1;
      end else begin
        latch_header   = 1'b1;
        burst.bytes[0] = item.class_byte;
        burst.bytes[1] = item.instruction_byte;
        burst.bytes[2] = item.param_one;
        burst.bytes[3] = item.param_two;
        burst.count    = 3'd5;
        case (item.case_type)
          CASE1: begin
            if (protocol_t1) burst.count = 3'd4;
          end
          CASE2S: burst.bytes[4] = item.expected_length[7:0];
          CASE2E: begin
            if (protocol_t1) begin
              burst.bytes[5] = item.expected_length[15:8];
              burst.bytes[6] = item.expected_length[7:0];
              burst.count    = 3'd7;
            end else begin
              burst.bytes[4] = item.expected_length[7:0];
            end
          end
          CASE3E, CASE4E: begin
            if (protocol_t1) begin
              burst.bytes[5] = item.command_length[15:8];
              burst.bytes[6] = item.command_length[7:0];
              burst.count    = 3'd7;
            end else begin
              burst.bytes[4] = item.command_length[7:0];
            end
          end
          default: burst.bytes[4] = item.command_length[7:0];
        endcase
        data_remaining_next = (item.case_type inside {[CASE3S:CASE4E]})
                              ? item.command_length : 16'd0;
        if (data_remaining_next != 16'd0) begin
          phase_next = PH_DATA;
        end else if (hdr_suffix) begin
          phase_next = PH_SUFFIX;
        end else begin
          burst.last = 1'b1;
        end
      end
    end else begin
      case (phase)
        PH_DATA: begin
          data_remaining_next = rem_dec;
          burst.bytes[0]      = item.data_byte;
          burst.count         = 3'd1;
          if (rem_dec == 16'd0) begin
            phase_next = PH_IDLE;
            burst.last = 1'b1;
            if (held_suffix) begin
              if (held_case == CASE4E) begin
                burst.bytes[1] = held_expected[15:8];
                burst.bytes[2] = held_expected[7:0];
                burst.count    = 3'd3;
              end else begin
                burst.bytes[1] = held_expected[7:0];
                burst.count    = 3'd2;
              end
            end
          end
        end
        PH_SUFFIX: begin
          phase_next = PH_IDLE;
          burst.last = 1'b1;
          if (held_case == CASE4E) begin
            burst.bytes[0] = held_expected[15:8];
            burst.bytes[1] = held_expected[7:0];
            burst.count    = 3'd2;
          end else begin
            burst.bytes[0] = held_expected[7:0];
            burst.count    = 3'd1;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      data_remaining <= '0;
      held_case      <= '0;
      held_expected  <= '0;
      held_length    <= '0;
      held_t1        <= 1'b0;
    end else if (take) begin
      phase          <= phase_next;
      data_remaining <= data_remaining_next;
      if (latch_header) begin
        held_case     <= item.case_type;
        held_expected <= item.expected_length;
        held_length   <= hdr_len;
        held_t1       <= protocol_t1;
      end
    end
  end

`ifndef SYNTHESIS
  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (data_remaining != 16'd0))
    else $error("data phase with no bytes remaining");

  a_suffix_t1: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SUFFIX) |-> held_suffix)
    else $error("suffix phase for a frame without suffix");
`endif

endmodule

### rtl/apdu_fr_burst.sv
module apdu_fr_burst
  import apdu_fr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  burst_t burst_in,
  output logic   ready,
  input  logic   pop,
  output logic   valid,
  output logic   [7:0] out_byte,
  output logic   last,
  output status_t status,
  output logic   [LEN_W-1:0] length
);

  logic [MAX_BEATS-1:0][7:0] bytes;
  logic [BEAT_CNT_W-1:0]     count;
  logic                      burst_last;

  assign valid    = (count != '0);
  assign ready    = (count == '0) || (count == BEAT_CNT_W'(1) && pop);
  assign out_byte = bytes[0];
  assign last     = burst_last && (count == BEAT_CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= burst_in.count;
    end else if (pop && valid) begin
      count <= count - BEAT_CNT_W'(1);
    end
  end

  // Payload: load a fresh burst or shift the next beat to the front
  always_ff @(posedge clk) begin
    if (load) begin
      bytes      <= burst_in.bytes;
      burst_last <= burst_in.last;
      status     <= burst_in.status;
      length     <= burst_in.length;
    end else if (pop && valid) begin
      bytes <= {8'h00, bytes[MAX_BEATS-1:1]};
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= BEAT_CNT_W'(MAX_BEATS))
    else $error("burst count out of range");

  a_length_hold: assert property (@(posedge clk) disable iff (rst)
    (count > BEAT_CNT_W'(1) && pop) |=> $stable(length))
    else $error("frame length changed inside a burst");
`endif

endmodule

### rtl/apdu_command_framer.sv
// Command APDU framer. A header beat (s_tuser = 0) carries CLA, INS, P1, P2,
// the case type, Lc and Le; the block computes the frame length, checks it
// against buffer_capacity and emits the header bytes plus the Lc or Le
// prefix as a burst of up to seven output beats. Data beats (s_tuser = 1)
// then pass one Lc data byte each. On T=1, a frame that carries both command
// data and an expected length sends its Le suffix after the last data byte
// (or on the next data beat when Lc is 0). Every
// output beat carries the frame length and a status; a rejected header
// yields one beat with tlast set and a nonzero status. Throughput: a data
// beat that yields one byte flows at one beat per clock while m_tready is
// high; an item yielding N output beats occupies the output burst register
// until all N have left, which sets the input stall. An accepted beat passes
// through the input register, then the burst register. A header beat always
// abandons an unfinished frame. Write protocol_t1 and buffer_capacity only
// while the block is idle; protocol_t1 is latched per frame at its header.
module apdu_command_framer
  import apdu_fr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [16:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // case_type[2:0], class_byte[10:3], instruction_byte[18:11], param_one[26:19],
  // param_two[34:27], command_length[50:35], expected_length[66:51],
  // data_byte[74:67], zero fill[79:75]
  input  logic [79:0] s_tdata,
  // mode[0]
  input  logic        s_tuser,
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_byte[7:0], frame_length[24:8], zero fill[31:25]
  output logic [31:0] m_tdata,
  // status[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  logic             protocol_t1;
  logic [LEN_W-1:0] buffer_capacity;

  logic             in_valid;
  item_t            in_item;
  logic             take;
  logic             burst_ready;
  burst_t           burst;
  logic [7:0]       out_byte;
  status_t          out_status;
  logic [LEN_W-1:0] out_length;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_t1     <= 1'b0;
      buffer_capacity <= CAPACITY_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PROTOCOL_T1:     protocol_t1     <= cfg_data[0];
        CFG_BUFFER_CAPACITY: buffer_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: advance into the burst stage once the burst register
  // will be free, so while m_tready is high a fresh data beat lands every cycle.
  assign take     = in_valid && burst_ready;
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.mode             <= s_tuser;
      in_item.case_type        <= s_tdata[2:0];
      in_item.class_byte       <= s_tdata[10:3];
      in_item.instruction_byte <= s_tdata[18:11];
      in_item.param_one        <= s_tdata[26:19];
      in_item.param_two        <= s_tdata[34:27];
      in_item.command_length   <= s_tdata[50:35];
      in_item.expected_length  <= s_tdata[66:51];
      in_item.data_byte        <= s_tdata[74:67];
    end
  end

  apdu_fr_core u_core (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .item            (in_item),
    .protocol_t1     (protocol_t1),
    .buffer_capacity (buffer_capacity),
    .burst           (burst)
  );

  apdu_fr_burst u_burst (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .burst_in (burst),
    .ready    (burst_ready),
    .pop      (m_tready),
    .valid    (m_tvalid),
    .out_byte (out_byte),
    .last     (m_tlast),
    .status   (out_status),
    .length   (out_length)
  );

  assign m_tdata = {7'd0, out_length, out_byte};
  assign m_tuser = out_status;

`ifndef SYNTHESIS
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> m_tlast)
    else $error("error beat without tlast");
`endif

endmodule
